[hw/rtl/crs_pkg.sv]
`default_nettype none
package crs_pkg;
   localparam int RowsPerChunk = 64;
   localparam int MaxRows = 512;
   localparam int MaxWidth = 1024;
   localparam int NumChunks = (MaxRows + RowsPerChunk - 1) / RowsPerChunk;
   localparam int ChunkBits = $clog2(NumChunks);
   localparam int RowBits = $clog2(MaxRows);
   localparam int ColBits = $clog2(MaxWidth);
   localparam int AddrBits = RowBits + ColBits;
   localparam int RowInChunkBits = $clog2(RowsPerChunk);
   localparam int QueueDepth = 2;

   typedef enum logic [2:0] {
      OP_CONFIGURE = 3'd0,
      OP_UNCONFIGURE = 3'd1,
      OP_DISCARD = 3'd2,
      OP_RESIZE = 3'd3,
      OP_WRITE = 3'd4,
      OP_READ = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_REJECTED = 2'd1,
      ST_NO_DATA = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [8:0] row_index;
      logic [9:0] column;
      logic [7:0] pixel_value;
      logic [10:0] new_width;
      logic [9:0] row_count;
   } item_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_value;
      logic [3:0] allocated_chunks;
      logic [19:0] allocated_bytes;
   } result_type;
endpackage
`default_nettype wire

[hw/rtl/chunked_row_store_with_rescale_core.sv]
// Every item ends with a pass that sums the 8 chunk marks into the result.
// A first write into an unmarked chunk first zero-fills that chunk's rows;
// resize rescales each row of a marked chunk and skips unmarked rows.
// One item is in work at a time; a two-entry queue holds later transfers.
// Reset is synchronous, active high; it clears all marks and unconfigures.
`default_nettype none
module chunked_row_store_with_rescale_core import crs_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // opcode, row_index, column, pixel_value, new_width, row_count, pad
   input wire logic [55:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // status, read_value, allocated_chunks, allocated_bytes, pad
   output logic [39:0] rsp_tdata
);
   item_type in_item, q_item;
   result_type res;
   logic q_valid, q_ready;

   assign in_item = '{opcode: req_tdata[2:0], row_index: req_tdata[11:3],
      column: req_tdata[21:12], pixel_value: req_tdata[29:22],
      new_width: req_tdata[40:30], row_count: req_tdata[50:41]};
   assign rsp_tdata = {6'd0, res.allocated_bytes, res.allocated_chunks,
      res.read_value, res.status};

   crs_front u_front (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item, .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));
   crs_back u_back (.clock, .reset, .in_valid(q_valid), .in_ready(q_ready),
      .in_item(q_item), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_result(res));
endmodule
`default_nettype wire

[hw/rtl/crs_front.sv]
`default_nettype none
module crs_front import crs_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire item_type in_item,
   output logic out_valid,
   input wire logic out_ready,
   output item_type out_item
);
   item_type queue_ff [QueueDepth];
   logic [$clog2(QueueDepth)-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [$clog2(QueueDepth):0] count_ff, count_in;
   logic push, pop;

   assign in_ready = count_ff != QueueDepth[$clog2(QueueDepth):0];
   assign out_valid = count_ff != '0;
   assign out_item = queue_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + {{$clog2(QueueDepth){1'b0}}, push}
         - {{$clog2(QueueDepth){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= in_item;
      end
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueDepth) else $error("queue overflow");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1) else $error("count");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      count_ff == 0 |-> !out_valid) else $error("empty pop");
`endif
endmodule
`default_nettype wire

[hw/rtl/crs_back.sv]
`default_nettype none
module crs_back import crs_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire item_type in_item,
   output logic out_valid,
   input wire logic out_ready,
   output result_type out_result
);
   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_READ, S_FILL, S_RS_LOAD, S_RS_LWAIT, S_RS_DIV,
      S_RS_RD, S_RS_WR, S_SUM, S_DONE
   } state_type;

   logic [7:0] store [MaxRows * MaxWidth];
   logic [7:0] line_buf [MaxWidth];

   state_type state_ff;
   item_type item_ff;
   logic [NumChunks-1:0] alloc_ff;
   logic [10:0] width_ff, old_width_ff;
   logic [9:0] rows_ff;
   logic [1:0] status_ff;
   logic [7:0] rv_ff;
   logic [ChunkBits:0] chunk_ff;
   logic [RowBits:0] row_ff;
   logic [10:0] x_ff;
   logic [7:0] mem_q_ff, lb_q_ff;
   logic mem_we;
   logic [AddrBits-1:0] mem_wa, mem_ra;
   logic [7:0] mem_wd;
   logic [3:0] chunks_ff;
   logic [19:0] bytes_ff;
   logic [ChunkBits:0] sum_ff;
   // Divider: quotient of x*old/new, one bit a cycle.
   logic [21:0] dividend_ff;
   logic [10:0] rem_ff;
   logic [4:0] div_cnt_ff;
   logic [11:0] rem_trial;
   logic [ColBits-1:0] src_x;
   logic [ChunkBits-1:0] ci;
   logic [RowBits:0] first_row;
   logic [RowBits:0] rows_left;
   logic [RowBits:0] chunk_rows;
   logic configured;
   logic [RowBits-1:0] cur_row;

   assign configured = width_ff != '0 && rows_ff != '0;
   assign ci = item_ff.row_index[RowBits-1 -: ChunkBits];
   assign cur_row = row_ff[RowBits-1:0];
   assign in_ready = state_ff == S_IDLE;
   assign out_valid = state_ff == S_DONE;
   assign out_result = '{status: status_ff, read_value: rv_ff,
      allocated_chunks: chunks_ff, allocated_bytes: bytes_ff};

   always_comb begin
      first_row = {1'b0, sum_ff[ChunkBits-1:0], {RowInChunkBits{1'b0}}};
      rows_left = {1'b0, rows_ff[RowBits-1:0]} - first_row;
      if (rows_ff[9]) rows_left = (RowBits+1)'(MaxRows) - first_row;
      if ({1'b0, rows_ff} <= {1'b0, first_row}) chunk_rows = '0;
      else if (rows_left > (RowBits+1)'(RowsPerChunk))
         chunk_rows = (RowBits+1)'(RowsPerChunk);
      else chunk_rows = rows_left;
      rem_trial = {rem_ff, dividend_ff[21]};
      src_x = (dividend_ff[10:0] > old_width_ff - 11'd1) ?
         ColBits'(old_width_ff - 11'd1) : ColBits'(dividend_ff[10:0]);
      mem_we = 1'b0;
      mem_wa = {cur_row, x_ff[ColBits-1:0]};
      mem_wd = '0;
      mem_ra = {item_ff.row_index, item_ff.column};
      case (state_ff)
         S_EXEC: begin
            if (item_ff.opcode == OP_WRITE && status_ff == ST_OK &&
                  alloc_ff[ci]) begin
               mem_we = 1'b1;
               mem_wa = {item_ff.row_index, item_ff.column};
               mem_wd = item_ff.pixel_value;
            end
         end
         S_FILL: mem_we = 1'b1;
         S_RS_LOAD: mem_ra = {cur_row, x_ff[ColBits-1:0]};
         S_RS_WR: begin
            mem_we = 1'b1;
            mem_wd = lb_q_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) store[mem_wa] <= mem_wd;
      mem_q_ff <= store[mem_ra];
      if (state_ff == S_RS_LWAIT) line_buf[x_ff[ColBits-1:0] - 1'b1] <= mem_q_ff;
      lb_q_ff <= line_buf[src_x];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         alloc_ff <= '0;
         width_ff <= '0;
         rows_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (in_valid) begin
               item_ff <= in_item;
               state_ff <= S_EXEC;
               status_ff <= ST_OK;
               rv_ff <= '0;
               if ((in_item.opcode == OP_WRITE || in_item.opcode == OP_READ) &&
                     (width_ff == '0 || rows_ff == '0 ||
                      {1'b0, in_item.row_index} >= rows_ff ||
                      {1'b0, in_item.column} >= width_ff))
                  status_ff <= ST_REJECTED;
            end
            S_EXEC: begin
               state_ff <= S_SUM;
               case (item_ff.opcode)
                  OP_CONFIGURE: begin
                     if (item_ff.new_width == '0 || item_ff.row_count == '0) begin
                        width_ff <= '0;
                        rows_ff <= '0;
                        alloc_ff <= '0;
                     end else if (item_ff.new_width > 11'(MaxWidth) ||
                           item_ff.row_count > 10'(MaxRows)) begin
                        status_ff <= ST_REJECTED;
                     end else if (!(item_ff.new_width == width_ff &&
                           item_ff.row_count == rows_ff)) begin
                        width_ff <= item_ff.new_width;
                        rows_ff <= item_ff.row_count;
                        alloc_ff <= '0;
                     end
                  end
                  OP_UNCONFIGURE: begin
                     width_ff <= '0;
                     rows_ff <= '0;
                     alloc_ff <= '0;
                  end
                  OP_DISCARD: alloc_ff <= '0;
                  OP_RESIZE: begin
                     if (!configured || item_ff.new_width == '0 ||
                           item_ff.new_width > 11'(MaxWidth))
                        status_ff <= ST_REJECTED;
                     else if (item_ff.new_width != width_ff) begin
                        old_width_ff <= width_ff;
                        row_ff <= '0;
                        x_ff <= '0;
                        state_ff <= S_RS_LOAD;
                     end
                  end
                  OP_WRITE: if (status_ff == ST_OK && !alloc_ff[ci]) begin
                     row_ff <= {1'b0, ci, {RowInChunkBits{1'b0}}};
                     x_ff <= '0;
                     state_ff <= S_FILL;
                  end
                  OP_READ: if (status_ff == ST_OK) begin
                     if (!alloc_ff[ci]) status_ff <= ST_NO_DATA;
                     else state_ff <= S_READ;
                  end
                  default: status_ff <= ST_REJECTED;
               endcase
               sum_ff <= '0;
               chunks_ff <= '0;
               bytes_ff <= '0;
            end
            S_READ: begin
               rv_ff <= mem_q_ff;
               state_ff <= S_SUM;
            end
            S_FILL: begin
               if (x_ff + 11'd1 >= width_ff) begin
                  x_ff <= '0;
                  row_ff <= row_ff + 1'b1;
                  if (row_ff + 1'b1 >= {1'b0, rows_ff[RowBits-1:0]} + (rows_ff[9] ?
                        (RowBits+1)'(MaxRows) : '0) ||
                        (row_ff[RowInChunkBits-1:0] == {RowInChunkBits{1'b1}})) begin
                     alloc_ff[ci] <= 1'b1;
                     state_ff <= S_EXEC;
                  end
               end else x_ff <= x_ff + 11'd1;
            end
            S_RS_LOAD: begin
               if (row_ff >= {1'b0, rows_ff[RowBits-1:0]} + (rows_ff[9] ?
                     (RowBits+1)'(MaxRows) : '0)) begin
                  width_ff <= item_ff.new_width;
                  state_ff <= S_SUM;
               end else if (!alloc_ff[row_ff[RowBits-1 -: ChunkBits]]) begin
                  row_ff <= row_ff + 1'b1;
               end else begin
                  x_ff <= x_ff + 11'd1;
                  state_ff <= S_RS_LWAIT;
               end
            end
            S_RS_LWAIT: begin
               if (x_ff >= old_width_ff) begin
                  x_ff <= '0;
                  dividend_ff <= '0;
                  rem_ff <= '0;
                  div_cnt_ff <= '0;
                  state_ff <= S_RS_DIV;
               end else state_ff <= S_RS_LOAD;
            end
            S_RS_DIV: begin
               if (div_cnt_ff == 5'd0) begin
                  dividend_ff <= 22'(x_ff) * 22'(old_width_ff);
                  rem_ff <= '0;
                  div_cnt_ff <= 5'd1;
               end else if (div_cnt_ff <= 5'd22) begin
                  if (rem_trial >= {1'b0, item_ff.new_width}) begin
                     rem_ff <= 11'(rem_trial - {1'b0, item_ff.new_width});
                     dividend_ff <= {dividend_ff[20:0], 1'b1};
                  end else begin
                     rem_ff <= rem_trial[10:0];
                     dividend_ff <= {dividend_ff[20:0], 1'b0};
                  end
                  div_cnt_ff <= div_cnt_ff + 5'd1;
               end else state_ff <= S_RS_RD;
            end
            S_RS_RD: state_ff <= S_RS_WR;
            S_RS_WR: begin
               div_cnt_ff <= '0;
               if (x_ff + 11'd1 >= item_ff.new_width) begin
                  x_ff <= '0;
                  row_ff <= row_ff + 1'b1;
                  state_ff <= S_RS_LOAD;
               end else begin
                  x_ff <= x_ff + 11'd1;
                  state_ff <= S_RS_DIV;
               end
            end
            S_SUM: begin
               if (sum_ff == (ChunkBits+1)'(NumChunks)) state_ff <= S_DONE;
               else begin
                  if (alloc_ff[sum_ff[ChunkBits-1:0]]) begin
                     chunks_ff <= chunks_ff + 4'd1;
                     bytes_ff <= bytes_ff + 20'(chunk_rows) * 20'(width_ff);
                  end
                  sum_ff <= sum_ff + 1'b1;
               end
            end
            S_DONE: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_cfg_unconf: assert property (@(posedge clock) disable iff (reset)
      width_ff == '0 |-> alloc_ff == '0 || state_ff != S_DONE)
      else $error("marks without config");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_result))
      else $error("result changed");
   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && status_ff != ST_OK |-> rv_ff == '0) else $error("rv");
`endif
endmodule
`default_nettype wire

[tb/tb_chunked_row_store_with_rescale_checker.sv]
`default_nettype none
module tb_chunked_row_store_with_rescale_checker import crs_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic [55:0] req_tdata,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [39:0] rsp_tdata,
   output int errors,
   output int pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0] pix_mem [0:MaxRows*MaxWidth-1];
   logic chunk_mark [0:NumChunks-1];
   int unsigned cur_width;
   int unsigned cur_rows;
   result_type rsp_fifo [$];

   initial begin
      errors = 0;
   end

   assign pending = rsp_fifo.size();

   function automatic int unsigned chunk_rows(int unsigned c);
      int unsigned first;
      int unsigned left;
      first = c * RowsPerChunk;
      if (first >= cur_rows) return 0;
      left = cur_rows - first;
      return (left < RowsPerChunk) ? left : RowsPerChunk;
   endfunction

   task automatic clear_all_marks();
      for (int c = 0; c < NumChunks; c++) chunk_mark[c] = 1'b0;
   endtask

   task automatic rescale_rows(int unsigned nw);
      logic [7:0] line [0:MaxWidth-1];
      int unsigned ow;
      int unsigned base;
      int unsigned sx;
      ow = cur_width;
      for (int c = 0; c < NumChunks; c++) begin
         if (chunk_mark[c]) begin
            for (int r = 0; r < chunk_rows(c); r++) begin
               base = (c * RowsPerChunk + r) * MaxWidth;
               for (int x = 0; x < ow; x++) line[x] = pix_mem[base + x];
               for (int x = 0; x < nw; x++) begin
                  sx = (x * ow) / nw;
                  if (sx > ow - 1) sx = ow - 1;
                  pix_mem[base + x] = line[sx];
               end
            end
         end
      end
      cur_width = nw;
   endtask

   task automatic predict_result(input logic [55:0] d, output result_type res);
      logic [2:0] op;
      int unsigned row, col, nw, nr, ci, addr, b, bytes, chunks;
      logic [7:0] val;
      logic configured;
      op = d[2:0];
      row = 32'(d[11:3]);
      col = 32'(d[21:12]);
      val = d[29:22];
      nw = 32'(d[40:30]);
      nr = 32'(d[50:41]);
      res = '0;
      res.status = ST_OK;
      configured = (cur_width != 0) && (cur_rows != 0);
      case (op)
         OP_CONFIGURE: begin
            if (nw == 0 || nr == 0) begin
               cur_width = 0;
               cur_rows = 0;
               clear_all_marks();
            end else if (nw > MaxWidth || nr > MaxRows) begin
               res.status = ST_REJECTED;
            end else if (!(nw == cur_width && nr == cur_rows)) begin
               cur_width = nw;
               cur_rows = nr;
               clear_all_marks();
            end
         end
         OP_UNCONFIGURE: begin
            cur_width = 0;
            cur_rows = 0;
            clear_all_marks();
         end
         OP_DISCARD: clear_all_marks();
         OP_RESIZE: begin
            if (!configured || nw == 0 || nw > MaxWidth) res.status = ST_REJECTED;
            else if (nw != cur_width) rescale_rows(nw);
         end
         OP_WRITE, OP_READ: begin
            if (!configured || row >= cur_rows || col >= cur_width) begin
               res.status = ST_REJECTED;
            end else begin
               ci = row / RowsPerChunk;
               addr = row * MaxWidth + col;
               if (op == OP_WRITE) begin
                  if (!chunk_mark[ci]) begin
                     for (int r = 0; r < chunk_rows(ci); r++) begin
                        b = (ci * RowsPerChunk + r) * MaxWidth;
                        for (int x = 0; x < cur_width; x++) pix_mem[b + x] = 8'h00;
                     end
                     chunk_mark[ci] = 1'b1;
                  end
                  pix_mem[addr] = val;
               end else if (!chunk_mark[ci]) begin
                  res.status = ST_NO_DATA;
               end else begin
                  res.read_value = pix_mem[addr];
               end
            end
         end
         default: res.status = ST_REJECTED;
      endcase
      chunks = 0;
      bytes = 0;
      for (int c = 0; c < NumChunks; c++) begin
         if (chunk_mark[c]) begin
            chunks++;
            bytes += chunk_rows(c) * cur_width;
         end
      end
      res.allocated_chunks = chunks[3:0];
      res.allocated_bytes = bytes[19:0];
   endtask

   always @(posedge clock) begin
      result_type exp_res;
      result_type got;
      if (reset) begin
         cur_width = 0;
         cur_rows = 0;
         clear_all_marks();
         rsp_fifo.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_result(req_tdata, exp_res);
            rsp_fifo.push_back(exp_res);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.read_value = rsp_tdata[9:2];
            got.allocated_chunks = rsp_tdata[13:10];
            got.allocated_bytes = rsp_tdata[33:14];
            if (rsp_fifo.size() == 0) begin
               $display("%0t: unexpected result transfer %h", $time, rsp_tdata);
               errors++;
            end else begin
               exp_res = rsp_fifo.pop_front();
               if (got.status != exp_res.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                     exp_res.status, got.status);
                  errors++;
               end
               if (got.read_value != exp_res.read_value) begin
                  $display("%0t: read_value expected %0d actual %0d", $time,
                     exp_res.read_value, got.read_value);
                  errors++;
               end
               if (got.allocated_chunks != exp_res.allocated_chunks) begin
                  $display("%0t: allocated_chunks expected %0d actual %0d", $time,
                     exp_res.allocated_chunks, got.allocated_chunks);
                  errors++;
               end
               if (got.allocated_bytes != exp_res.allocated_bytes) begin
                  $display("%0t: allocated_bytes expected %0d actual %0d", $time,
                     exp_res.allocated_bytes, got.allocated_bytes);
                  errors++;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

[tb/tb_chunked_row_store_with_rescale_core.sv]
`default_nettype none
module tb_chunked_row_store_with_rescale_core;
   import crs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [55:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   int errors;
   int pending;
   int idle_pct = 20;
   int hold_cycles = 0;
   int shadow_w = 0;
   int shadow_r = 0;

   always #2 clock = ~clock;

   chunked_row_store_with_rescale_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   tb_chunked_row_store_with_rescale_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .errors(errors), .pending(pending)
   );

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic send_item(logic [2:0] op, int row, int col, int val, int nw, int nr);
      logic [55:0] d;
      d = '0;
      d[2:0] = op;
      d[11:3] = 9'(row);
      d[21:12] = 10'(col);
      d[29:22] = 8'(val);
      d[40:30] = 11'(nw);
      d[50:41] = 10'(nr);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      #40ms;
      $display("tb_chunked_row_store_with_rescale_core: errors");
      $finish;
   end

   initial begin
      int pick, row, col, nw, nr;
      logic [2:0] op;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_READ, 0, 0, 0, 0, 0);
      send_item(OP_RESIZE, 0, 0, 0, 5, 0);
      send_item(OP_CONFIGURE, 0, 0, 0, 1025, 1);
      send_item(OP_CONFIGURE, 0, 0, 0, 1, 513);
      send_item(OP_CONFIGURE, 0, 0, 0, 1024, 512);
      send_item(OP_WRITE, 511, 1023, 255, 0, 0);
      send_item(OP_READ, 511, 1023, 0, 0, 0);
      send_item(OP_READ, 0, 0, 0, 0, 0);
      send_item(OP_CONFIGURE, 0, 0, 0, 1024, 512);
      send_item(OP_RESIZE, 0, 0, 0, 1024, 0);
      send_item(OP_RESIZE, 0, 0, 0, 1, 0);
      send_item(OP_READ, 511, 0, 0, 0, 0);
      send_item(OP_READ, 511, 1, 0, 0, 0);
      send_item(OP_DISCARD, 0, 0, 0, 0, 0);
      send_item(OP_CONFIGURE, 0, 0, 0, 1024, 1);
      send_item(OP_WRITE, 0, 0, 8'hAA, 0, 0);
      send_item(OP_WRITE, 0, 1023, 8'h55, 0, 0);
      send_item(OP_RESIZE, 0, 0, 0, 3, 0);
      send_item(OP_RESIZE, 0, 0, 0, 1024, 0);
      send_item(OP_READ, 0, 1023, 0, 0, 0);
      send_item(OP_READ, 1, 0, 0, 0, 0);
      send_item(OP_CONFIGURE, 0, 0, 0, 0, 7);
      send_item(3'd6, 0, 0, 0, 0, 0);
      send_item(3'd7, 0, 0, 0, 0, 0);
      send_item(OP_UNCONFIGURE, 0, 0, 0, 0, 0);
      drain_results();

      hold_cycles = 400;
      for (int i = 0; i < 700; i++) begin
         idle_pct = (i >= 300 && i < 400) ? 0 : 20;
         if (i == 500) drain_results();
         pick = $urandom_range(99);
         row = $urandom_range((shadow_r > 0) ? shadow_r - 1 : 0);
         col = $urandom_range((shadow_w > 0) ? shadow_w - 1 : 0);
         if ($urandom_range(9) == 0) row = $urandom_range(shadow_r, shadow_r + 3);
         if ($urandom_range(9) == 0) col = $urandom_range(shadow_w, shadow_w + 3);
         if (pick < 40) begin
            send_item(OP_WRITE, row, col, $urandom_range(255), 0, 0);
         end else if (pick < 75) begin
            send_item(OP_READ, row, col, 0, 0, 0);
         end else if (pick < 79) begin
            nw = $urandom_range(1, 12);
            send_item(OP_RESIZE, 0, 0, 0, nw, 0);
            if (shadow_w != 0 && shadow_r != 0) shadow_w = nw;
         end else if (pick < 87) begin
            if ($urandom_range(3) != 0) begin
               shadow_w = $urandom_range(1, 12);
               shadow_r = $urandom_range(1, 80);
            end
            send_item(OP_CONFIGURE, 0, 0, 0, shadow_w, shadow_r);
         end else if (pick < 90) begin
            send_item(OP_DISCARD, 0, 0, 0, 0, 0);
         end else if (pick < 92) begin
            send_item(OP_UNCONFIGURE, 0, 0, 0, 0, 0);
            shadow_w = 0;
            shadow_r = 0;
         end else begin
            op = 3'($urandom_range(7));
            nw = $urandom_range(2047);
            nr = $urandom_range(1023);
            if (op == OP_CONFIGURE || op == OP_RESIZE || op == OP_UNCONFIGURE) begin
               nw = 1025 + $urandom_range(1022);
               op = (op == OP_UNCONFIGURE) ? 3'd6 : op;
            end
            send_item(op, $urandom_range(511), $urandom_range(1023),
               $urandom_range(255), nw, nr);
         end
      end
      drain_results();
      repeat (200) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("tb_chunked_row_store_with_rescale_core: clean");
      end else begin
         $display("tb_chunked_row_store_with_rescale_core: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
